[rtl/core/tsi_pkg.sv]
// tsi_pkg: shared types, widths and command codes of the snapshot interpolator
// no dependencies; used by the channel interfaces, the interpolator unit and the testbench
package tsi_pkg;

   localparam int CMD_W   = 2;
   localparam int POS_W   = 32;
   localparam int ANG_W   = 16;
   localparam int TIME_W  = 32;
   localparam int DELAY_W = 16;
   localparam int FRAC_W  = 16;
   localparam int STEP_W  = 5;

   localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd100;
   localparam logic [FRAC_W:0]    FRAC_ONE    = 17'h10000;
   localparam logic [STEP_W-1:0]  LAST_STEP   = 5'd16;

   localparam logic [CMD_W-1:0] CMD_SNAP  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DEATH = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

   // one stored snapshot, dead mark kept in its own ram
   typedef struct packed {
      logic [POS_W-1:0]  x;
      logic [POS_W-1:0]  y;
      logic [ANG_W-1:0]  angle;
      logic [TIME_W-1:0] stamp;
   } snap_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_DIV,
      ST_MUL,
      ST_SUM,
      ST_EMIT
   } state_type;

endpackage

[rtl/core/tsi_channels.sv]
// tsi_channels: valid/ready channel interfaces for request and response transactions
// depends on tsi_pkg for field widths
interface tsi_req_if;
   logic                              valid;
   logic                              ready;
   logic [tsi_pkg::CMD_W-1:0]         command;
   logic signed [tsi_pkg::POS_W-1:0]  pos_x;
   logic signed [tsi_pkg::POS_W-1:0]  pos_y;
   logic [tsi_pkg::ANG_W-1:0]         angle_in;
   logic [tsi_pkg::TIME_W-1:0]        time_in;

   modport source (output valid, command, pos_x, pos_y, angle_in, time_in, input ready);
   modport sink   (input valid, command, pos_x, pos_y, angle_in, time_in, output ready);
endinterface

interface tsi_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [tsi_pkg::POS_W-1:0]  out_x;
   logic signed [tsi_pkg::POS_W-1:0]  out_y;
   logic [tsi_pkg::ANG_W-1:0]         out_angle;
   logic                              killed;

   modport source (output valid, out_x, out_y, out_angle, killed, input ready);
   modport sink   (input valid, out_x, out_y, out_angle, killed, output ready);
endinterface

[rtl/core/tsi_ram.sv]
// tsi_ram: generic single write port, single read port ram with registered read
// no dependencies
module tsi_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/timestamped_snapshot_interpolator_unit.sv]
// timestamped_snapshot_interpolator_unit: snapshot ring with bit-serial interpolation
// tick: each history entry checked passes ST_READ and ST_CHECK, then ST_EMIT follows; when
// interpolating, the ST_DIV division, ST_MUL scaling and ST_SUM states come before ST_EMIT
// response valid right after emit; input ready again the cycle after emit
// one transaction at a time; snapshot, death and empty-history tick transactions stay in idle
// reset: synchronous, empties the history and sets delay_ff to 100
module timestamped_snapshot_interpolator_unit #(
   parameter int HISTORY_DEPTH = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   tsi_req_if.sink                       req_bus,
   tsi_rsp_if.source                     rsp_bus,
   input  logic                          csr_wr_en,
   input  logic [tsi_pkg::DELAY_W-1:0]   csr_wr_data
);

   localparam int AW = $clog2(HISTORY_DEPTH);
   localparam int CW = $clog2(HISTORY_DEPTH + 1);
   localparam logic [AW:0]   DEPTH_SLOT = (AW+1)'(HISTORY_DEPTH);
   localparam logic [AW-1:0] LAST_SLOT  = AW'(HISTORY_DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_CNT  = CW'(HISTORY_DEPTH);
   localparam logic [CW-1:0] ONE_CNT    = CW'(1);

   localparam int PW = tsi_pkg::POS_W;
   localparam int GW = tsi_pkg::ANG_W;
   localparam int TW = tsi_pkg::TIME_W;
   localparam int FW = tsi_pkg::FRAC_W;

   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                             input logic [AW-1:0] ofs);
      logic [AW:0] sum;
      sum = {1'b0, base} + {1'b0, ofs};
      if (sum >= DEPTH_SLOT) begin
         sum = sum - DEPTH_SLOT;
      end
      return sum[AW-1:0];
   endfunction

   tsi_pkg::state_type state_ff, state_in;

   logic [tsi_pkg::DELAY_W-1:0] delay_ff;
   logic [CW-1:0]               count_ff;
   logic [AW-1:0]               oldest_ff;
   logic [CW-1:0]               idx_ff;
   logic [TW-1:0]               now_ff;
   tsi_pkg::snap_type           prev_ff;

   logic [TW:0]                 rem_ff;
   logic [TW-1:0]               span_ff;
   logic [FW:0]                 quo_ff;
   logic [tsi_pkg::STEP_W-1:0]  step_ff;

   logic [PW:0]                 dlt_x_ff, dlt_y_ff;
   logic [GW-1:0]               dlt_a_ff;
   logic [PW:0]                 mag_x_ff, mag_y_ff, acc_x_ff, acc_y_ff;
   logic [GW:0]                 mag_a_ff, acc_a_ff;
   logic                        neg_x_ff, neg_y_ff, neg_a_ff;

   tsi_pkg::snap_type           res_ff;
   logic                        res_kill_ff;

   logic                        rsp_valid_ff;
   logic [PW-1:0]               out_x_ff, out_y_ff;
   logic [GW-1:0]               out_angle_ff;
   logic                        killed_ff;

   logic                        req_fire, rsp_free;
   logic                        snap_wr, dead_wr;
   logic [AW-1:0]               wr_slot, rd_slot;
   logic [CW-1:0]               cnt_m1;
   tsi_pkg::snap_type           wr_snap, rd_snap;
   logic                        rd_dead;

   logic                        is_first, is_last, now_le_tn, tn_le_tp, now_le_tp;
   logic [TW:0]                 div_trial;
   logic                        div_bit;
   logic                        fbit;
   logic [PW+1:0]               sum_x, sum_y;
   logic [GW+1:0]               sum_a;

   // ------------------------------------------------------------------
   // handshake
   assign req_fire = req_bus.valid && req_bus.ready;
   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;

   // ------------------------------------------------------------------
   // history write path
   assign cnt_m1  = count_ff - ONE_CNT;
   assign snap_wr = req_fire && (req_bus.command == tsi_pkg::CMD_SNAP);
   assign dead_wr = snap_wr || (req_fire && (req_bus.command == tsi_pkg::CMD_DEATH)
                                && (count_ff != '0));

   always_comb begin
      if (req_bus.command == tsi_pkg::CMD_SNAP) begin
         wr_slot = (count_ff == DEPTH_CNT) ? oldest_ff
                                           : slot_of(oldest_ff, count_ff[AW-1:0]);
      end else begin
         wr_slot = slot_of(oldest_ff, cnt_m1[AW-1:0]);
      end
   end

   assign wr_snap.x     = req_bus.pos_x;
   assign wr_snap.y     = req_bus.pos_y;
   assign wr_snap.angle = req_bus.angle_in;
   assign wr_snap.stamp = req_bus.time_in + {{(TW-tsi_pkg::DELAY_W){1'b0}}, delay_ff};

   assign rd_slot = slot_of(oldest_ff, idx_ff[AW-1:0]);

   tsi_ram #(
      .WIDTH ($bits(tsi_pkg::snap_type)),
      .DEPTH (HISTORY_DEPTH)
   ) u_snap_ram (
      .clock   (clock),
      .wr_en   (snap_wr),
      .wr_addr (wr_slot),
      .wr_data (wr_snap),
      .rd_addr (rd_slot),
      .rd_data (rd_snap)
   );

   tsi_ram #(
      .WIDTH (1),
      .DEPTH (HISTORY_DEPTH)
   ) u_dead_ram (
      .clock   (clock),
      .wr_en   (dead_wr),
      .wr_addr (wr_slot),
      .wr_data (req_bus.command == tsi_pkg::CMD_DEATH),
      .rd_addr (rd_slot),
      .rd_data (rd_dead)
   );

   // ------------------------------------------------------------------
   // scan compares
   assign is_first  = (idx_ff == '0);
   assign is_last   = ((idx_ff + ONE_CNT) == count_ff);
   assign now_le_tn = (now_ff <= rd_snap.stamp);
   assign tn_le_tp  = (rd_snap.stamp <= prev_ff.stamp);
   assign now_le_tp = (now_ff <= prev_ff.stamp);

   // restoring division step, one quotient bit per cycle
   assign div_trial = (step_ff == '0) ? {1'b0, rem_ff[TW-1:0]} : {rem_ff[TW-1:0], 1'b0};
   assign div_bit   = (div_trial >= {1'b0, span_ff});

   // lsb-first shift-add scaling, one fraction bit per cycle
   assign fbit  = quo_ff[0];
   assign sum_x = {1'b0, acc_x_ff} + (fbit ? {1'b0, mag_x_ff} : '0);
   assign sum_y = {1'b0, acc_y_ff} + (fbit ? {1'b0, mag_y_ff} : '0);
   assign sum_a = {1'b0, acc_a_ff} + (fbit ? {1'b0, mag_a_ff} : '0);

   // ------------------------------------------------------------------
   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tsi_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and ready
   always_comb begin
      state_in      = state_ff;
      req_bus.ready = 1'b0;
      unique case (state_ff)
         tsi_pkg::ST_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_fire && (req_bus.command == tsi_pkg::CMD_TICK) && (count_ff != '0)) begin
               state_in = tsi_pkg::ST_READ;
            end
         end
         tsi_pkg::ST_READ: begin
            state_in = tsi_pkg::ST_CHECK;
         end
         tsi_pkg::ST_CHECK: begin
            priority if (is_first) begin
               state_in = (count_ff == ONE_CNT) ? tsi_pkg::ST_EMIT : tsi_pkg::ST_READ;
            end else if (now_le_tn) begin
               state_in = (tn_le_tp || now_le_tp) ? tsi_pkg::ST_EMIT : tsi_pkg::ST_DIV;
            end else begin
               state_in = is_last ? tsi_pkg::ST_EMIT : tsi_pkg::ST_READ;
            end
         end
         tsi_pkg::ST_DIV: begin
            if (step_ff == tsi_pkg::LAST_STEP) begin
               state_in = tsi_pkg::ST_MUL;
            end
         end
         tsi_pkg::ST_MUL: begin
            if (step_ff == tsi_pkg::LAST_STEP) begin
               state_in = tsi_pkg::ST_SUM;
            end
         end
         tsi_pkg::ST_SUM: begin
            state_in = tsi_pkg::ST_EMIT;
         end
         tsi_pkg::ST_EMIT: begin
            if (rsp_free) begin
               state_in = tsi_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tsi_pkg::ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // configuration and ring pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff  <= tsi_pkg::DELAY_RESET;
         count_ff  <= '0;
         oldest_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            delay_ff <= csr_wr_data;
         end
         if (snap_wr) begin
            if (count_ff == DEPTH_CNT) begin
               oldest_ff <= (oldest_ff == LAST_SLOT) ? '0 : oldest_ff + AW'(1);
            end else begin
               count_ff <= count_ff + ONE_CNT;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // scan, division and scaling datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         tsi_pkg::ST_IDLE: begin
            now_ff <= req_bus.time_in;
            idx_ff <= '0;
         end
         tsi_pkg::ST_READ: begin
         end
         tsi_pkg::ST_CHECK: begin
            step_ff      <= '0;
            quo_ff       <= '0;
            rem_ff       <= {1'b0, now_ff - prev_ff.stamp};
            span_ff      <= rd_snap.stamp - prev_ff.stamp;
            dlt_x_ff     <= {rd_snap.x[PW-1], rd_snap.x} - {prev_ff.x[PW-1], prev_ff.x};
            dlt_y_ff     <= {rd_snap.y[PW-1], rd_snap.y} - {prev_ff.y[PW-1], prev_ff.y};
            dlt_a_ff     <= rd_snap.angle - prev_ff.angle;
            res_kill_ff  <= 1'b0;
            priority if (is_first) begin
               prev_ff <= rd_snap;
               res_ff  <= rd_snap;
               idx_ff  <= ONE_CNT;
            end else if (now_le_tn) begin
               res_ff <= tn_le_tp ? rd_snap : prev_ff;
            end else begin
               prev_ff     <= rd_snap;
               res_ff      <= rd_snap;
               res_kill_ff <= rd_dead;
               idx_ff      <= idx_ff + ONE_CNT;
            end
         end
         tsi_pkg::ST_DIV: begin
            // the first step also turns the differences into sign and magnitude
            if (step_ff == '0) begin
               neg_x_ff <= dlt_x_ff[PW];
               neg_y_ff <= dlt_y_ff[PW];
               neg_a_ff <= dlt_a_ff[GW-1];
               mag_x_ff <= dlt_x_ff[PW] ? -dlt_x_ff : dlt_x_ff;
               mag_y_ff <= dlt_y_ff[PW] ? -dlt_y_ff : dlt_y_ff;
               mag_a_ff <= dlt_a_ff[GW-1] ? -{1'b1, dlt_a_ff} : {1'b0, dlt_a_ff};
            end
            rem_ff   <= div_bit ? div_trial - {1'b0, span_ff} : div_trial;
            quo_ff   <= {quo_ff[FW-1:0], div_bit};
            acc_x_ff <= '0;
            acc_y_ff <= '0;
            acc_a_ff <= '0;
            step_ff  <= (step_ff == tsi_pkg::LAST_STEP) ? '0
                                                        : step_ff + tsi_pkg::STEP_W'(1);
         end
         tsi_pkg::ST_MUL: begin
            quo_ff <= quo_ff >> 1;
            if (step_ff == tsi_pkg::LAST_STEP) begin
               acc_x_ff <= sum_x[PW:0];
               acc_y_ff <= sum_y[PW:0];
               acc_a_ff <= sum_a[GW:0];
               step_ff  <= '0;
            end else begin
               acc_x_ff <= sum_x[PW+1:1];
               acc_y_ff <= sum_y[PW+1:1];
               acc_a_ff <= sum_a[GW+1:1];
               step_ff  <= step_ff + tsi_pkg::STEP_W'(1);
            end
         end
         tsi_pkg::ST_SUM: begin
            res_ff.x     <= neg_x_ff ? prev_ff.x - acc_x_ff[PW-1:0]
                                     : prev_ff.x + acc_x_ff[PW-1:0];
            res_ff.y     <= neg_y_ff ? prev_ff.y - acc_y_ff[PW-1:0]
                                     : prev_ff.y + acc_y_ff[PW-1:0];
            res_ff.angle <= neg_a_ff ? prev_ff.angle - acc_a_ff[GW-1:0]
                                     : prev_ff.angle + acc_a_ff[GW-1:0];
            res_kill_ff  <= 1'b0;
         end
         tsi_pkg::ST_EMIT: begin
         end
         default: begin
         end
      endcase
   end

   // ------------------------------------------------------------------
   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == tsi_pkg::ST_EMIT) && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == tsi_pkg::ST_EMIT) && rsp_free) begin
         out_x_ff     <= res_ff.x;
         out_y_ff     <= res_ff.y;
         out_angle_ff <= res_ff.angle;
         killed_ff    <= res_kill_ff;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.out_x     = out_x_ff;
   assign rsp_bus.out_y     = out_y_ff;
   assign rsp_bus.out_angle = out_angle_ff;
   assign rsp_bus.killed    = killed_ff;

   // ------------------------------------------------------------------
   // assertions
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("history count beyond depth");

   a_oldest_until_full: assert property (@(posedge clock) disable iff (reset)
      (count_ff != DEPTH_CNT) |-> (oldest_ff == '0))
      else $error("oldest slot moved before the ring filled");

   a_empty_tick: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_bus.command == tsi_pkg::CMD_TICK) && (count_ff == '0))
      |=> (state_ff == tsi_pkg::ST_IDLE))
      else $error("tick on empty history started a scan");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == tsi_pkg::ST_EMIT))
      else $error("response raised outside the emit state");

   a_frac_range: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == tsi_pkg::ST_MUL) && (step_ff == '0)) |-> (quo_ff <= tsi_pkg::FRAC_ONE))
      else $error("interpolation fraction above one");

endmodule

[bench/timestamped_snapshot_interpolator_unit_tb.sv]
// testbench for timestamped_snapshot_interpolator_unit: directed and random snapshot,
// death, tick and spare transactions checked against a behavioral predictor of the ring
// depends on tsi_pkg, tsi_channels and the rtl top level
module timestamped_snapshot_interpolator_unit_tb;

   localparam int DEPTH      = 8;
   localparam int EXP_DEPTH  = 64;
   localparam int LONG_STALL = 300;

   typedef struct packed {
      logic [tsi_pkg::POS_W-1:0] x;
      logic [tsi_pkg::POS_W-1:0] y;
      logic [tsi_pkg::ANG_W-1:0] angle;
      logic                      killed;
   } pose_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [tsi_pkg::DELAY_W-1:0] csr_wr_data = '0;

   tsi_req_if req_bus ();
   tsi_rsp_if rsp_bus ();

   timestamped_snapshot_interpolator_unit #(.HISTORY_DEPTH(DEPTH)) u_top (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   // predictor state
   logic [tsi_pkg::POS_W-1:0]  ring_x [DEPTH];
   logic [tsi_pkg::POS_W-1:0]  ring_y [DEPTH];
   logic [tsi_pkg::ANG_W-1:0]  ring_ang [DEPTH];
   logic [tsi_pkg::TIME_W-1:0] ring_stamp [DEPTH];
   logic                       ring_dead [DEPTH];
   int                         ring_head = 0;
   int                         ring_fill = 0;
   logic [tsi_pkg::DELAY_W-1:0] delay_reg = tsi_pkg::DELAY_RESET;

   // expected poses in order, written by the sender and read by the checker
   pose_type exp_mem [EXP_DEPTH];
   int exp_wr = 0;
   int exp_rd = 0;

   int errors = 0;
   int poses_seen = 0;
   int ticks_sent = 0;
   int hold_off;
   int long_cnt;
   bit long_hold = 0;
   logic [tsi_pkg::TIME_W-1:0] clock_ms = 0;

   initial forever #5 clock = ~clock;

   function automatic void store_pose(pose_type p);
      exp_mem[exp_wr % EXP_DEPTH] = p;
      exp_wr++;
   endfunction

   function automatic pose_type take_pose();
      pose_type p;
      p = exp_mem[exp_rd % EXP_DEPTH];
      exp_rd++;
      return p;
   endfunction

   function automatic int pending_count();
      return exp_wr - exp_rd;
   endfunction

   function automatic logic [tsi_pkg::POS_W-1:0] blend_pos(logic [tsi_pkg::POS_W-1:0] a,
                                                           logic [tsi_pkg::POS_W-1:0] b,
                                                           longint f);
      longint sa, d, p, r;
      sa = longint'($signed(a));
      d = longint'($signed(b)) - sa;
      p = d * f;
      r = sa + ((p >= 0) ? (p >>> 16) : -((-p) >>> 16));
      return r[tsi_pkg::POS_W-1:0];
   endfunction

   function automatic logic [tsi_pkg::ANG_W-1:0] blend_angle(logic [tsi_pkg::ANG_W-1:0] a,
                                                             logic [tsi_pkg::ANG_W-1:0] b,
                                                             longint f);
      logic [tsi_pkg::ANG_W-1:0] d;
      longint sd, p, r;
      d = b - a;
      sd = longint'($signed(d));
      p = sd * f;
      r = longint'(a) + ((p >= 0) ? (p >>> 16) : -((-p) >>> 16));
      return r[tsi_pkg::ANG_W-1:0];
   endfunction

   function automatic pose_type ring_pose(int k, logic kill);
      pose_type p;
      int s;
      s = (ring_head + k) % DEPTH;
      p.x = ring_x[s];
      p.y = ring_y[s];
      p.angle = ring_ang[s];
      p.killed = kill;
      return p;
   endfunction

   // update ring state for one accepted transaction; a tick on a non-empty ring stores the expected pose
   task automatic predict_pose(logic [tsi_pkg::CMD_W-1:0] cmd, logic [tsi_pkg::POS_W-1:0] px,
                               logic [tsi_pkg::POS_W-1:0] py, logic [tsi_pkg::ANG_W-1:0] ang,
                               logic [tsi_pkg::TIME_W-1:0] tin);
      int s, i, ps, ns;
      logic [tsi_pkg::TIME_W-1:0] tp, tn;
      longint f;
      pose_type p;
      if (cmd == tsi_pkg::CMD_SNAP) begin
         if (ring_fill >= DEPTH) begin
            ring_head = (ring_head + 1) % DEPTH;
            ring_fill = DEPTH - 1;
         end
         s = (ring_head + ring_fill) % DEPTH;
         ring_x[s] = px;
         ring_y[s] = py;
         ring_ang[s] = ang;
         ring_stamp[s] = tin + tsi_pkg::TIME_W'(delay_reg);
         ring_dead[s] = 1'b0;
         ring_fill++;
      end else if (cmd == tsi_pkg::CMD_DEATH) begin
         if (ring_fill > 0) ring_dead[(ring_head + ring_fill - 1) % DEPTH] = 1'b1;
      end else if (cmd == tsi_pkg::CMD_TICK && ring_fill > 0) begin
         if (ring_fill == 1) begin
            store_pose(ring_pose(0, 1'b0));
            return;
         end
         for (i = 1; i < ring_fill; i++) begin
            ps = (ring_head + i - 1) % DEPTH;
            ns = (ring_head + i) % DEPTH;
            tp = ring_stamp[ps];
            tn = ring_stamp[ns];
            if (tin <= tn) begin
               if (tn <= tp) p = ring_pose(i, 1'b0);
               else if (tin <= tp) p = ring_pose(i - 1, 1'b0);
               else begin
                  f = (longint'(tin - tp) << 16) / longint'(tn - tp);
                  p.x = blend_pos(ring_x[ps], ring_x[ns], f);
                  p.y = blend_pos(ring_y[ps], ring_y[ns], f);
                  p.angle = blend_angle(ring_ang[ps], ring_ang[ns], f);
                  p.killed = 1'b0;
               end
               store_pose(p);
               return;
            end
         end
         s = (ring_head + ring_fill - 1) % DEPTH;
         store_pose(ring_pose(ring_fill - 1, ring_dead[s]));
      end
   endtask

   // send one transaction and predict it on acceptance; valid stays up for the next one
   task automatic send_item(logic [tsi_pkg::CMD_W-1:0] cmd, logic [tsi_pkg::POS_W-1:0] px,
                            logic [tsi_pkg::POS_W-1:0] py, logic [tsi_pkg::ANG_W-1:0] ang,
                            logic [tsi_pkg::TIME_W-1:0] tin, bit gaps);
      int g;
      g = 0;
      if (gaps) begin
         g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
         if ($urandom_range(0, 3) == 0) g = 0;
      end
      if (g > 0) begin
         req_bus.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.command <= cmd;
      req_bus.pos_x <= px;
      req_bus.pos_y <= py;
      req_bus.angle_in <= ang;
      req_bus.time_in <= tin;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_pose(cmd, px, py, ang, tin);
      if (cmd == tsi_pkg::CMD_TICK) ticks_sent++;
   endtask

   // wait until every expected pose has been checked, with a bound
   task automatic drain();
      int guard;
      req_bus.valid <= 1'b0;
      guard = 0;
      while (pending_count() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
   endtask

   // idle the block, then write the delay register
   task automatic write_delay(logic [tsi_pkg::DELAY_W-1:0] v);
      drain();
      repeat (80) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      delay_reg = v;
   endtask

   // response side: random stalls plus one long hold-off counted here
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_off <= 0;
         long_cnt <= 0;
      end else if (long_hold && long_cnt < LONG_STALL) begin
         rsp_bus.ready <= 1'b0;
         long_cnt <= long_cnt + 1;
      end else if (hold_off > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_off <= hold_off - 1;
      end else if ($urandom_range(0, 9) < 3) begin
         rsp_bus.ready <= 1'b0;
         hold_off <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 80) : 0;
      end else rsp_bus.ready <= 1'b1;
   end

   // compare each accepted response with the oldest expected pose
   always @(posedge clock) begin : chk
      pose_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         poses_seen++;
         if (pending_count() == 0) begin
            $display("%0t unexpected response x=%h y=%h angle=%h killed=%b", $time,
                     rsp_bus.out_x, rsp_bus.out_y, rsp_bus.out_angle, rsp_bus.killed);
            errors++;
         end else begin
            want = take_pose();
            if (rsp_bus.out_x !== want.x) begin
               $display("%0t out_x expected %h actual %h", $time, want.x, rsp_bus.out_x);
               errors++;
            end
            if (rsp_bus.out_y !== want.y) begin
               $display("%0t out_y expected %h actual %h", $time, want.y, rsp_bus.out_y);
               errors++;
            end
            if (rsp_bus.out_angle !== want.angle) begin
               $display("%0t out_angle expected %h actual %h", $time, want.angle,
                        rsp_bus.out_angle);
               errors++;
            end
            if (rsp_bus.killed !== want.killed) begin
               $display("%0t killed expected %b actual %b", $time, want.killed,
                        rsp_bus.killed);
               errors++;
            end
         end
      end
   end

   // empty ring, single entry, extremes, ties and death handling
   task automatic test_directed();
      send_item(tsi_pkg::CMD_TICK, 0, 0, 0, 32'd500, 0);
      send_item(tsi_pkg::CMD_DEATH, 0, 0, 0, 0, 0);
      send_item(tsi_pkg::CMD_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 0);
      send_item(tsi_pkg::CMD_SNAP, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 32'd0, 0);
      send_item(tsi_pkg::CMD_TICK, 0, 0, 0, 32'd50, 0);
      send_item(tsi_pkg::CMD_SNAP, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0001, 32'd1000, 0);
      send_item(tsi_pkg::CMD_TICK, 0, 0, 0, 32'd0, 0);
      send_item(tsi_pkg::CMD_TICK, 0, 0, 0, 32'd600, 0);
      send_item(tsi_pkg::CMD_TICK, 0, 0, 0, 32'd1100, 0);
      send_item(tsi_pkg::CMD_SNAP, 32'h1234_5678, 32'hFEDC_BA98, 16'h8001, 32'd1000, 0);
      send_item(tsi_pkg::CMD_TICK, 0, 0, 0, 32'd1100, 0);
      send_item(tsi_pkg::CMD_SNAP, 32'h0, 32'h0, 16'h0001, 32'd900, 0);
      send_item(tsi_pkg::CMD_TICK, 0, 0, 0, 32'd1150, 0);
      send_item(tsi_pkg::CMD_DEATH, 0, 0, 0, 0, 0);
      send_item(tsi_pkg::CMD_TICK, 0, 0, 0, 32'hFFFF_FFFF, 0);
      send_item(tsi_pkg::CMD_TICK, 0, 0, 0, 32'hFFFF_FFFF, 0);
      send_item(tsi_pkg::CMD_SNAP, 32'h5555_AAAA, 32'hAAAA_5555, 16'h7FFF, 32'hFFFF_FFF0, 0);
      send_item(tsi_pkg::CMD_TICK, 0, 0, 0, 32'd20, 0);
   endtask

   // well-formed snapshot streams with ticks between, plus noise
   task automatic test_random(int count);
      int n, r;
      logic [tsi_pkg::POS_W-1:0] rx, ry;
      for (n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         rx = ($urandom_range(0, 3) == 0) ? $urandom() : $signed($urandom_range(0, 65535) << 8)
              - 32'sh0080_0000;
         ry = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 1 << 24);
         if (r < 35) begin
            clock_ms += $urandom_range(0, 40);
            send_item(tsi_pkg::CMD_SNAP, rx, ry, 16'($urandom()),
                      ($urandom_range(0, 19) == 0) ? $urandom() : clock_ms, 1);
         end else if (r < 40) send_item(tsi_pkg::CMD_DEATH, 0, 0, 0, $urandom(), 1);
         else if (r < 42) send_item(tsi_pkg::CMD_SPARE, $urandom(), $urandom(),
                                    16'($urandom()), $urandom(), 1);
         else begin
            send_item(tsi_pkg::CMD_TICK, $urandom(), $urandom(), 16'($urandom()),
                      ($urandom_range(0, 9) == 0) ? $urandom()
                      : clock_ms + delay_reg - 200 + $urandom_range(0, 400), 1);
            if ($urandom_range(0, 2) == 0) clock_ms += $urandom_range(0, 20);
         end
      end
   endtask

   // hold the response side off while ticks keep coming
   task automatic test_backpressure();
      int n;
      send_item(tsi_pkg::CMD_SNAP, 32'h0001_0000, 32'h0002_0000, 16'h1000, clock_ms, 0);
      long_hold = 1;
      fork
         begin
            for (n = 0; n < 12; n++) send_item(tsi_pkg::CMD_TICK, 0, 0, 0, clock_ms + n * 7, 0);
         end
         begin
            while (long_cnt < LONG_STALL) @(posedge clock);
            long_hold = 0;
         end
      join
   endtask

   initial begin
      req_bus.valid <= 1'b0;
      req_bus.command <= tsi_pkg::CMD_SNAP;
      req_bus.pos_x <= '0;
      req_bus.pos_y <= '0;
      req_bus.angle_in <= '0;
      req_bus.time_in <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_random(600);
      write_delay(16'd0);
      test_random(400);
      write_delay(16'hFFFF);
      test_random(400);
      write_delay(16'd37);
      test_random(420);
      drain();
      repeat (100) @(posedge clock);
      $display("covered %0d ticks and %0d checked poses over four delay settings",
               ticks_sent, poses_seen);
      if (errors == 0 && pending_count() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #20000000;
      $display("Test completed with failures");
      $finish;
   end
endmodule

[sim.f]
rtl/core/tsi_pkg.sv
rtl/core/tsi_channels.sv
rtl/core/tsi_ram.sv
rtl/core/timestamped_snapshot_interpolator_unit.sv
bench/timestamped_snapshot_interpolator_unit_tb.sv
